FILE: hdl/hssc_pkg.sv
// Shared types, constants and helpers of the seven-point stencil core.
`default_nettype none
package hssc_pkg;

   localparam int DATA_W    = 32;
   localparam int POS_W     = 7;
   localparam int CSR_IDX_W = 3;
   localparam int SIZE_CAP  = 64;

   // widths inside the arithmetic pipe
   localparam int DIFF_W = DATA_W + 3;        // e + w - 2c
   localparam int PROD_W = DATA_W + 1 + DIFF_W; // unsigned coeff times diff
   localparam int PSUM_W = PROD_W + 1;
   localparam int ACC_W  = PROD_W + 2;
   localparam int FRAC_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SIZE_X  = 3'd0,
      REG_SIZE_Y  = 3'd1,
      REG_SIZE_Z  = 3'd2,
      REG_COEFF_X = 3'd3,
      REG_COEFF_Y = 3'd4,
      REG_COEFF_Z = 3'd5
   } csr_index_type;

   // flags of one accepted beat, from the address generator to the pipe
   typedef struct packed {
      logic hit;   // beat completes an owned point
      logic last;  // that point is the final one of the grid
   } point_type;

   // zero counts as one, anything above the limit counts as the limit
   function automatic logic [POS_W-1:0] eff_size(logic [POS_W-1:0] v,
                                                 logic [POS_W-1:0] lim);
      logic [POS_W-1:0] r;
      begin
         if (v == '0) r = POS_W'(1);
         else if (v > lim) r = lim;
         else r = v;
         return r;
      end
   endfunction

endpackage
`default_nettype wire

FILE: hdl/hssc_sample_ram.sv
// Sample plane store: one write port, two registered read ports.
`default_nettype none
module hssc_sample_ram #(
   parameter int DEPTH = 8712,
   parameter int AW    = 14
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [AW-1:0]              wr_addr,
   input  wire logic [hssc_pkg::DATA_W-1:0] wr_data,
   input  wire logic                       rd_en,
   input  wire logic [AW-1:0]              rd_addr_a,
   input  wire logic [AW-1:0]              rd_addr_b,
   output logic      [hssc_pkg::DATA_W-1:0] rd_data_a,
   output logic      [hssc_pkg::DATA_W-1:0] rd_data_b
);
   import hssc_pkg::*;

   logic [DATA_W-1:0] mem [DEPTH];

   // read returns the old word when the same address is written this cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule
`default_nettype wire

FILE: hdl/hssc_addr_gen.sv
// Padded-grid position counters and plane buffer addressing.
`default_nettype none
module hssc_addr_gen #(
   parameter int MAX_X = 64,
   parameter int MAX_Y = 64,
   parameter int MAX_Z = 64,
   parameter int SAW   = 14,
   parameter int PAW   = 13
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      accept,
   input  wire logic [hssc_pkg::POS_W-1:0] size_x,
   input  wire logic [hssc_pkg::POS_W-1:0] size_y,
   input  wire logic [hssc_pkg::POS_W-1:0] size_z,
   output hssc_pkg::point_type            point,
   output logic [PAW-1:0]                 here_addr,
   output logic [SAW-1:0]                 in_addr,
   output logic [SAW-1:0]                 ctr_addr,
   output logic [SAW-1:0]                 east_addr,
   output logic [SAW-1:0]                 west_addr,
   output logic [SAW-1:0]                 north_addr,
   output logic [SAW-1:0]                 south_addr
);
   import hssc_pkg::*;

   localparam int ROW_LEN   = MAX_X + 2;
   localparam int PLANE_LEN = (MAX_X + 2) * (MAX_Y + 2);
   localparam int LIM_X     = (MAX_X < SIZE_CAP) ? MAX_X : SIZE_CAP;
   localparam int LIM_Y     = (MAX_Y < SIZE_CAP) ? MAX_Y : SIZE_CAP;
   localparam int LIM_Z     = (MAX_Z < SIZE_CAP) ? MAX_Z : SIZE_CAP;

   logic [POS_W-1:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic [POS_W-1:0] pos_x_in, pos_y_in, pos_z_in;
   logic [POS_W-1:0] ex, ey, ez, ez1;
   logic [SAW-1:0]   here_w, in_off, mid_off;

   assign ex  = eff_size(size_x, POS_W'(LIM_X));
   assign ey  = eff_size(size_y, POS_W'(LIM_Y));
   assign ez  = eff_size(size_z, POS_W'(LIM_Z));
   assign ez1 = ez + POS_W'(1);

   // raster walk over the padded grid, x fastest
   always_comb begin
      pos_x_in = pos_x_ff + POS_W'(1);
      pos_y_in = pos_y_ff;
      pos_z_in = pos_z_ff;
      if (pos_x_ff >= ex + POS_W'(1)) begin
         pos_x_in = '0;
         if (pos_y_ff >= ey + POS_W'(1)) begin
            pos_y_in = '0;
            pos_z_in = (pos_z_ff >= ez1) ? '0 : pos_z_ff + POS_W'(1);
         end else begin
            pos_y_in = pos_y_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         pos_z_ff <= '0;
      end else if (accept) begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         pos_z_ff <= pos_z_in;
      end
   end

   // owned point whose upper neighbor is this beat
   assign point.hit = (pos_x_ff >= POS_W'(1)) && (pos_x_ff <= ex) &&
                      (pos_y_ff >= POS_W'(1)) && (pos_y_ff <= ey) &&
                      (pos_z_ff >= POS_W'(2)) && (pos_z_ff <= ez1);
   assign point.last = (pos_x_ff == ex) && (pos_y_ff == ey) && (pos_z_ff == ez1);

   // plane-local offset, then plane selection by z parity
   assign here_w  = SAW'(pos_y_ff) * SAW'(ROW_LEN) + SAW'(pos_x_ff);
   assign in_off  = pos_z_ff[0] ? SAW'(PLANE_LEN) : '0;
   assign mid_off = pos_z_ff[0] ? '0 : SAW'(PLANE_LEN);

   assign here_addr  = here_w[PAW-1:0];
   assign in_addr    = in_off + here_w;
   assign ctr_addr   = mid_off + here_w;
   assign east_addr  = mid_off + here_w + SAW'(1);
   assign west_addr  = mid_off + here_w - SAW'(1);
   assign north_addr = mid_off + here_w + SAW'(ROW_LEN);
   assign south_addr = mid_off + here_w - SAW'(ROW_LEN);

endmodule
`default_nettype wire

FILE: hdl/hssc_arith.sv
// Stencil arithmetic pipeline: differences, products, sums, round and saturate.
`default_nettype none
module hssc_arith (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       accept,
   input  hssc_pkg::point_type             point,
   input  wire logic [hssc_pkg::DATA_W-1:0] up_sample,
   input  wire logic [hssc_pkg::DATA_W-1:0] dn_sample,
   input  wire logic [hssc_pkg::DATA_W-1:0] ctr_sample,
   input  wire logic [hssc_pkg::DATA_W-1:0] east_sample,
   input  wire logic [hssc_pkg::DATA_W-1:0] west_sample,
   input  wire logic [hssc_pkg::DATA_W-1:0] north_sample,
   input  wire logic [hssc_pkg::DATA_W-1:0] south_sample,
   input  wire logic [hssc_pkg::DATA_W-1:0] shift_sample,
   input  wire logic [hssc_pkg::DATA_W-1:0] coeff_x,
   input  wire logic [hssc_pkg::DATA_W-1:0] coeff_y,
   input  wire logic [hssc_pkg::DATA_W-1:0] coeff_z,
   input  wire logic                       rsp_stall,
   output logic                            take_en,
   output logic                            rsp_valid,
   output logic signed [hssc_pkg::DATA_W-1:0] rsp_operator_value,
   output logic                            rsp_grid_done
);
   import hssc_pkg::*;

   logic en2, en3, en4, en5;

   // stage 1: neighbor words arrive from the plane buffers
   logic                     v1_ff, last1_ff;
   logic signed [DATA_W-1:0] up1_ff;
   // stage 2: second differences
   logic                     v2_ff, last2_ff;
   logic signed [DIFF_W-1:0] dx2_ff, dy2_ff, dz2_ff;
   logic signed [DATA_W-1:0] ctr2_ff, lam2_ff;
   logic signed [DIFF_W-1:0] dx_in, dy_in, dz_in, two_c;
   // stage 3: products
   logic                     v3_ff, last3_ff;
   logic signed [PROD_W-1:0] px3_ff, py3_ff, pz3_ff;
   logic signed [2*DATA_W-1:0] pl3_ff;
   // stage 4: partial sums
   logic                     v4_ff, last4_ff;
   logic signed [PSUM_W-1:0] sa4_ff, sb4_ff;
   // stage 5: output register
   logic                     v5_ff, last5_ff;
   logic signed [DATA_W-1:0] out5_ff;
   logic signed [ACC_W-1:0]  acc;
   logic signed [DATA_W-1:0] out_in;

   // bubbles collapse; a stage moves when the next one can take it
   assign en5     = !v5_ff || !rsp_stall;
   assign en4     = !v4_ff || en5;
   assign en3     = !v3_ff || en4;
   assign en2     = !v2_ff || en3;
   assign take_en = !v1_ff || en2;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (take_en) v1_ff <= accept && point.hit;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         last1_ff <= point.last;
         up1_ff   <= up_sample;
      end
   end

   // second differences along each axis
   always_comb begin
      two_c = DIFF_W'($signed(ctr_sample)) <<< 1;
      dx_in = DIFF_W'($signed(east_sample)) + DIFF_W'($signed(west_sample)) - two_c;
      dy_in = DIFF_W'($signed(north_sample)) + DIFF_W'($signed(south_sample)) - two_c;
      dz_in = DIFF_W'(up1_ff) + DIFF_W'($signed(dn_sample)) - two_c;
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         last2_ff <= last1_ff;
         dx2_ff   <= dx_in;
         dy2_ff   <= dy_in;
         dz2_ff   <= dz_in;
         ctr2_ff  <= $signed(ctr_sample);
         lam2_ff  <= $signed(shift_sample);
      end
   end

   // four products, one multiplier each
   always_ff @(posedge clock) begin
      if (en3) begin
         last3_ff <= last2_ff;
         px3_ff   <= $signed({1'b0, coeff_x}) * dx2_ff;
         py3_ff   <= $signed({1'b0, coeff_y}) * dy2_ff;
         pz3_ff   <= $signed({1'b0, coeff_z}) * dz2_ff;
         pl3_ff   <= lam2_ff * ctr2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         last4_ff <= last3_ff;
         sa4_ff   <= PSUM_W'(px3_ff) + PSUM_W'(py3_ff);
         sb4_ff   <= PSUM_W'(pz3_ff) - PSUM_W'(pl3_ff);
      end
   end

   // Q32.32 sum plus half an LSB of Q16.16, floor, then clamp to int32
   always_comb begin
      acc = ACC_W'(sa4_ff) + ACC_W'(sb4_ff) + ACC_W'(1 << (FRAC_W - 1));
      if ((&acc[ACC_W-1:DATA_W+FRAC_W-1]) || !(|acc[ACC_W-1:DATA_W+FRAC_W-1])) begin
         out_in = acc[DATA_W+FRAC_W-1:FRAC_W];
      end else if (acc[ACC_W-1]) begin
         out_in = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         out_in = {1'b0, {(DATA_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         last5_ff <= last4_ff;
         out5_ff  <= out_in;
      end
   end

   assign rsp_valid          = v5_ff;
   assign rsp_operator_value = out5_ff;
   assign rsp_grid_done      = last5_ff;

endmodule
`default_nettype wire

FILE: hdl/helmholtz_seven_point_stencil_core.sv
// Top level of the seven-point Helmholtz stencil core.
//
//  channel | direction | handshake          | beat carries
//  req_    | in        | req_valid/req_stall | field_sample, shift_value
//  rsp_    | out       | rsp_valid/rsp_stall | operator_value, grid_done
//  csr_    | in        | csr_valid/csr_ready | index, data (always ready)
//
// One beat per cycle unless req_stall; a result follows the beat of the
// sample one plane above its point. Three plane copies, two ports each, give
// six of the seven points, the beat the top one, the shift plane the shift.
// Reset clears counters and valids, presets CSRs; data, planes start unknown.
// A stalled output holds the pipe; empty stages still fill, then req_stall.
`default_nettype none
module helmholtz_seven_point_stencil_core #(
   parameter int MAX_X = 64,
   parameter int MAX_Y = 64,
   parameter int MAX_Z = 64
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic signed [hssc_pkg::DATA_W-1:0] req_field_sample,
   input  wire logic signed [hssc_pkg::DATA_W-1:0] req_shift_value,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic signed [hssc_pkg::DATA_W-1:0] rsp_operator_value,
   output logic                              rsp_grid_done,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [hssc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [hssc_pkg::DATA_W-1:0]  csr_data
);
   import hssc_pkg::*;

   localparam int PLANE_LEN = (MAX_X + 2) * (MAX_Y + 2);
   localparam int PAW       = $clog2(PLANE_LEN);
   localparam int SAW       = $clog2(2 * PLANE_LEN);

   logic [POS_W-1:0]  size_x_ff, size_y_ff, size_z_ff;
   logic [DATA_W-1:0] coeff_x_ff, coeff_y_ff, coeff_z_ff;
   logic              accept, take_en;
   point_type         point;
   logic [PAW-1:0]    here_addr;
   logic [SAW-1:0]    in_addr, ctr_addr, east_addr, west_addr, north_addr, south_addr;
   logic [DATA_W-1:0] dn_w, ctr_w, east_w, west_w, north_w, south_w;
   logic [DATA_W-1:0] lam_ff;
   logic [DATA_W-1:0] shift_mem [PLANE_LEN];

   assign csr_ready = 1'b1;
   assign req_stall = !take_en;
   assign accept    = req_valid && take_en;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff  <= POS_W'(SIZE_CAP);
         size_y_ff  <= POS_W'(SIZE_CAP);
         size_z_ff  <= POS_W'(SIZE_CAP);
         coeff_x_ff <= DATA_W'(1 << FRAC_W);
         coeff_y_ff <= DATA_W'(1 << FRAC_W);
         coeff_z_ff <= DATA_W'(1 << FRAC_W);
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            REG_SIZE_X:  size_x_ff  <= csr_data[POS_W-1:0];
            REG_SIZE_Y:  size_y_ff  <= csr_data[POS_W-1:0];
            REG_SIZE_Z:  size_z_ff  <= csr_data[POS_W-1:0];
            REG_COEFF_X: coeff_x_ff <= csr_data;
            REG_COEFF_Y: coeff_y_ff <= csr_data;
            REG_COEFF_Z: coeff_z_ff <= csr_data;
            default: ;
         endcase
      end
   end

   hssc_addr_gen #(
      .MAX_X(MAX_X), .MAX_Y(MAX_Y), .MAX_Z(MAX_Z), .SAW(SAW), .PAW(PAW)
   ) u_addr (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .size_x     (size_x_ff),
      .size_y     (size_y_ff),
      .size_z     (size_z_ff),
      .point      (point),
      .here_addr  (here_addr),
      .in_addr    (in_addr),
      .ctr_addr   (ctr_addr),
      .east_addr  (east_addr),
      .west_addr  (west_addr),
      .north_addr (north_addr),
      .south_addr (south_addr)
   );

   // plane copy for the point itself and its lower neighbor
   hssc_sample_ram #(.DEPTH(2 * PLANE_LEN), .AW(SAW)) u_ram_cd (
      .clock(clock), .wr_en(accept), .wr_addr(in_addr), .wr_data(req_field_sample),
      .rd_en(accept), .rd_addr_a(in_addr), .rd_addr_b(ctr_addr),
      .rd_data_a(dn_w), .rd_data_b(ctr_w)
   );

   // plane copy for the x neighbors
   hssc_sample_ram #(.DEPTH(2 * PLANE_LEN), .AW(SAW)) u_ram_ew (
      .clock(clock), .wr_en(accept), .wr_addr(in_addr), .wr_data(req_field_sample),
      .rd_en(accept), .rd_addr_a(east_addr), .rd_addr_b(west_addr),
      .rd_data_a(east_w), .rd_data_b(west_w)
   );

   // plane copy for the y neighbors
   hssc_sample_ram #(.DEPTH(2 * PLANE_LEN), .AW(SAW)) u_ram_ns (
      .clock(clock), .wr_en(accept), .wr_addr(in_addr), .wr_data(req_field_sample),
      .rd_en(accept), .rd_addr_a(north_addr), .rd_addr_b(south_addr),
      .rd_data_a(north_w), .rd_data_b(south_w)
   );

   // shift plane: old value read out as the new one goes in
   always_ff @(posedge clock) begin
      if (accept) begin
         shift_mem[here_addr] <= req_shift_value;
         lam_ff               <= shift_mem[here_addr];
      end
   end

   hssc_arith u_arith (
      .clock              (clock),
      .reset              (reset),
      .accept             (accept),
      .point              (point),
      .up_sample          (req_field_sample),
      .dn_sample          (dn_w),
      .ctr_sample         (ctr_w),
      .east_sample        (east_w),
      .west_sample        (west_w),
      .north_sample       (north_w),
      .south_sample       (south_w),
      .shift_sample       (lam_ff),
      .coeff_x            (coeff_x_ff),
      .coeff_y            (coeff_y_ff),
      .coeff_z            (coeff_z_ff),
      .rsp_stall          (rsp_stall),
      .take_en            (take_en),
      .rsp_valid          (rsp_valid),
      .rsp_operator_value (rsp_operator_value),
      .rsp_grid_done      (rsp_grid_done)
   );

endmodule
`default_nettype wire

FILE: hdl/hssc_checker.sv
// Port-level checks of the stencil core and their binding.
`default_nettype none
module hssc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [31:0] rsp_operator_value,
   input wire logic        rsp_grid_done
);

   // a stalled result beat stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped under stall");

   // and keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_operator_value) && $stable(rsp_grid_done))
      else $error("result payload changed under stall");

   // with the output free the input is never held off
   a_no_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled while output is free");

   // pipe is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat right after reset");

endmodule

bind helmholtz_seven_point_stencil_core hssc_checker u_hssc_checker (
   .clock              (clock),
   .reset              (reset),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_operator_value (rsp_operator_value),
   .rsp_grid_done      (rsp_grid_done)
);
`default_nettype wire
